FILE: sv/ldsbr_pkg.sv
`timescale 1ns / 1ps
package ldsbr_pkg;

  localparam int DEF_MAX_SLOTS     = 16;
  localparam int DEF_MAX_LOOKAHEAD = 8;
  localparam int DEF_NUM_BANDS     = 64;

  localparam int WEIGHT_DEPTH = 64;
  localparam int WEIGHT_W     = 16;
  localparam int BAND_W       = 6;
  localparam int VALUE_W      = 32;
  localparam int SUM_W        = 48;
  localparam int RATIO_W      = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int NUM_W        = SUM_W + 16;
  localparam int REM_W        = SUM_W + 2;
  localparam int DIV_W        = SUM_W + 1;
  localparam int DCNT_W       = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SLOTS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BAND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_BAND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_EN    = 3'd5;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_ENERGY = 1'b1;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_MUL  = 11'b00000000010,
    S_ACC  = 11'b00000000100,
    S_P1   = 11'b00000001000,
    S_P2   = 11'b00000010000,
    S_DIV  = 11'b00000100000,
    S_FIN  = 11'b00001000000,
    S_SEL  = 11'b00010000000,
    S_COPY = 11'b00100000000,
    S_OUT  = 11'b01000000000,
    S_SPARE = 11'b10000000000
  } state_t;

endpackage

FILE: sv/low_delay_sbr_transient_detector_top.sv
`timescale 1ns / 1ps
// low-delay sbr transient detector
// input channel (in_valid / in_stall): cmd 0 loads weight value[15:0] at index
// band; cmd 1 delivers the energy of one band, last_band closes the time slot.
// result channel (out_valid / out_stall): one transaction at every frame end
// with the strongest marked slot, a found flag and a look-ahead flag.
// config port (cfg_we / cfg_index / cfg_data): write only, while idle; a write
// of the frame length or look-ahead count restarts the current frame, history
// is kept.
// a weight load writes the ram directly; a band energy runs weight ram read,
// 32x16 multiply and saturating accumulate. a slot-closing band adds the reads
// of the two previous slots, the bit-serial 64-bit ratio divider and the
// history write; a frame-closing band adds the peak search over the frame
// slots, the look-ahead history carry and the result register load.
// in_stall is high while an item is being worked on.
// reset clears all history, the slot sum and the result valid flag; the weight
// table holds no reset value and must be loaded before use.
// when out_stall holds a result, the block keeps taking items and only waits
// at the next frame end until the pending result has been taken.
module low_delay_sbr_transient_detector_top
  import ldsbr_pkg::*;
#(
  parameter int MAX_SLOTS     = DEF_MAX_SLOTS,
  parameter int MAX_LOOKAHEAD = DEF_MAX_LOOKAHEAD,
  parameter int NUM_BANDS     = DEF_NUM_BANDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [BAND_W-1:0]     in_band,
  input  logic [VALUE_W-1:0]    in_value,
  input  logic                  in_last_band,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [3:0]            out_transient_slot,
  output logic                  out_transient_found,
  output logic                  out_lookahead_transient,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int HD  = MAX_SLOTS + MAX_LOOKAHEAD;
  localparam int IW  = $clog2(HD);
  localparam int SPW = $clog2(HD + 1);
  localparam int ABW = $clog2(WEIGHT_DEPTH);

  state_t state_r;

  logic [4:0]          frame_len_r;
  logic [3:0]          lead_slots_r;
  logic [5:0]          start_band_r;
  logic [6:0]          stop_band_r;
  logic [RATIO_W-1:0]  ratio_thr_r;
  logic [31:0]         small_en_r;

  logic [SUM_W-1:0]    eh_r [HD];
  logic [RATIO_W-1:0]  rh_r [HD];
  logic [HD-1:0]       mh_r;

  logic [SUM_W-1:0]    band_sum_r;
  logic [SPW-1:0]      slot_pos_r;
  logic [VALUE_W-1:0]  value_r;
  logic                last_r;
  logic                in_range_r;
  logic [SUM_W-1:0]    prod_r;
  logic [IW-1:0]       ts_r;
  logic [SUM_W-1:0]    p1_r;
  logic [SUM_W-1:0]    p2_r;
  logic                m1_r;
  logic                m2_r;
  logic                c1_r;
  logic                c2_r;
  logic [SUM_W+2:0]    five_e_r;
  logic [DIV_W-1:0]    div_r;
  logic [NUM_W-1:0]    num_r;
  logic [REM_W-1:0]    rem_r;
  logic [NUM_W-1:0]    q_r;
  logic [DCNT_W-1:0]   dcnt_r;
  logic [IW-1:0]       idx_r;
  logic [IW-1:0]       best_r;
  logic [RATIO_W-1:0]  best_ratio_r;
  logic                found_r;
  logic                la_mark_r;
  logic                out_valid_r;
  logic [3:0]          out_slot_r;
  logic                out_found_r;
  logic                out_la_r;

  logic                in_acc;
  logic [SPW-1:0]      ns_eff;
  logic [SPW-1:0]      la_eff;
  logic [6:0]          stop_eff;
  logic [WEIGHT_W-1:0] w_rdata;
  logic [SPW-1:0]      ts_clamp;
  logic [SUM_W:0]      sum_ext;
  logic [REM_W-1:0]    rem_sh;
  logic                q_bit;
  logic [RATIO_W-1:0]  ratio;
  logic                mark;
  logic [SUM_W+2:0]    seven_p1;
  logic [SUM_W+2:0]    seven_p2;
  logic [SPW-1:0]      src_idx;
  logic [SPW-1:0]      slot_next;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    if (frame_len_r == 5'd0) begin
      ns_eff = SPW'(1);
    end else if (32'(frame_len_r) > 32'(MAX_SLOTS)) begin
      ns_eff = SPW'(MAX_SLOTS);
    end else begin
      ns_eff = SPW'(frame_len_r);
    end
    if (lead_slots_r < 4'd2) begin
      la_eff = SPW'(2);
    end else if (32'(lead_slots_r) > 32'(MAX_LOOKAHEAD)) begin
      la_eff = SPW'(MAX_LOOKAHEAD);
    end else begin
      la_eff = SPW'(lead_slots_r);
    end
    stop_eff = (32'(stop_band_r) > 32'(NUM_BANDS)) ? 7'(NUM_BANDS) : stop_band_r;
    if (32'(slot_pos_r) >= 32'(HD)) begin
      ts_clamp = SPW'(HD - 1);
    end else if (slot_pos_r < SPW'(2)) begin
      ts_clamp = SPW'(2);
    end else begin
      ts_clamp = slot_pos_r;
    end
  end

  ldsbr_ram #(
    .WIDTH(WEIGHT_W),
    .DEPTH(WEIGHT_DEPTH)
  ) u_weight_ram (
    .clk  (clk),
    .we   (in_acc && (in_cmd == CMD_LOAD)),
    .waddr(ABW'(in_band)),
    .wdata(in_value[WEIGHT_W-1:0]),
    .raddr(ABW'(in_band - start_band_r)),
    .rdata(w_rdata)
  );

  assign sum_ext  = {1'b0, band_sum_r} + {1'b0, prod_r};
  assign rem_sh   = {rem_r[REM_W-2:0], num_r[NUM_W-1]};
  assign q_bit    = (rem_sh >= REM_W'(div_r));
  assign ratio    = (div_r == '0) ? ((band_sum_r != '0) ? '1 : '0)
                  : ((q_r[NUM_W-1:RATIO_W] != '0) ? '1 : q_r[RATIO_W-1:0]);
  assign mark     = (ratio >= ratio_thr_r) && ((!m1_r && !m2_r) || c1_r || c2_r);
  assign seven_p1 = {p1_r, 3'b000} - (SUM_W+3)'(p1_r);
  assign seven_p2 = {p2_r, 3'b000} - (SUM_W+3)'(p2_r);
  assign src_idx  = ns_eff + SPW'(idx_r);
  assign slot_next = SPW'(ts_r) + SPW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      frame_len_r  <= 5'd16;
      lead_slots_r <= 4'd2;
      start_band_r <= 6'd0;
      stop_band_r  <= 7'd64;
      ratio_thr_r  <= 32'd131072;
      small_en_r   <= 32'd1;
      band_sum_r   <= '0;
      slot_pos_r   <= SPW'(2);
      mh_r         <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < HD; i++) begin
        eh_r[i] <= '0;
        rh_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_LEN: begin
            frame_len_r <= cfg_data[4:0];
            band_sum_r  <= '0;
            slot_pos_r  <= la_eff;
          end
          CFG_LEAD_SLOTS: begin
            lead_slots_r <= cfg_data[3:0];
            band_sum_r   <= '0;
            if (cfg_data[3:0] < 4'd2) begin
              slot_pos_r <= SPW'(2);
            end else if (32'(cfg_data[3:0]) > 32'(MAX_LOOKAHEAD)) begin
              slot_pos_r <= SPW'(MAX_LOOKAHEAD);
            end else begin
              slot_pos_r <= SPW'(cfg_data[3:0]);
            end
          end
          CFG_START_BAND: start_band_r <= cfg_data[5:0];
          CFG_STOP_BAND:  stop_band_r  <= cfg_data[6:0];
          CFG_RATIO_THR:  ratio_thr_r  <= cfg_data;
          CFG_SMALL_EN:   small_en_r   <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_cmd == CMD_ENERGY)) begin
            value_r    <= in_value;
            last_r     <= in_last_band;
            in_range_r <= (in_band >= start_band_r) && ({1'b0, in_band} < stop_eff);
            state_r    <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= SUM_W'((SUM_W'(value_r) * SUM_W'(w_rdata)) >> 14);
          state_r <= S_ACC;
        end
        S_ACC: begin
          prod_r <= prod_r;
          if (in_range_r) begin
            band_sum_r <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
          end
          ts_r    <= IW'(ts_clamp);
          state_r <= last_r ? S_P1 : S_IDLE;
        end
        S_P1: begin
          p1_r     <= eh_r[ts_r - IW'(1)];
          m1_r     <= mh_r[ts_r - IW'(1)];
          div_r    <= DIV_W'(eh_r[ts_r - IW'(1)]) + DIV_W'(small_en_r);
          five_e_r <= {band_sum_r, 2'b00} + (SUM_W+3)'(band_sum_r);
          num_r    <= {band_sum_r, 16'h0000};
          rem_r    <= '0;
          q_r      <= '0;
          dcnt_r   <= '0;
          state_r  <= S_P2;
        end
        S_P2: begin
          p2_r    <= eh_r[ts_r - IW'(2)];
          m2_r    <= mh_r[ts_r - IW'(2)];
          c1_r    <= (five_e_r >= seven_p1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          c2_r   <= (five_e_r >= seven_p2);
          rem_r  <= q_bit ? (rem_sh - REM_W'(div_r)) : rem_sh;
          q_r    <= {q_r[NUM_W-2:0], q_bit};
          num_r  <= {num_r[NUM_W-2:0], 1'b0};
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == '1) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          eh_r[ts_r]   <= band_sum_r;
          rh_r[ts_r]   <= ratio;
          mh_r[ts_r]   <= mark;
          band_sum_r   <= '0;
          slot_pos_r   <= slot_next;
          idx_r        <= '0;
          best_r       <= '0;
          best_ratio_r <= '0;
          found_r      <= 1'b0;
          la_mark_r    <= 1'b0;
          state_r      <= (slot_next >= ns_eff + la_eff) ? S_SEL : S_IDLE;
        end
        S_SEL: begin
          if (mh_r[idx_r] && (rh_r[idx_r] > best_ratio_r)) begin
            best_ratio_r <= rh_r[idx_r];
            best_r       <= idx_r;
            found_r      <= 1'b1;
          end
          if (SPW'(idx_r) == ns_eff - SPW'(1)) begin
            idx_r   <= '0;
            state_r <= S_COPY;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        S_COPY: begin
          eh_r[idx_r] <= eh_r[IW'(src_idx)];
          rh_r[idx_r] <= rh_r[IW'(src_idx)];
          mh_r[idx_r] <= mh_r[IW'(src_idx)];
          if (mh_r[IW'(src_idx)]) begin
            la_mark_r <= 1'b1;
          end
          if (SPW'(idx_r) == la_eff - SPW'(1)) begin
            state_r <= S_OUT;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        S_OUT: begin
          if (!(out_valid_r && out_stall)) begin
            out_valid_r <= 1'b1;
            out_slot_r  <= found_r ? 4'(best_r) : 4'd0;
            out_found_r <= found_r;
            out_la_r    <= la_mark_r;
            slot_pos_r  <= la_eff;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid               = out_valid_r;
  assign out_transient_slot      = out_slot_r;
  assign out_transient_found     = out_found_r;
  assign out_lookahead_transient = out_la_r;

endmodule

FILE: sv/ldsbr_ram.sv
`timescale 1ns / 1ps
module ldsbr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
